### design/gnf_pkg.sv
package gnf_pkg;

  localparam int unsigned CoordW = 32;
  localparam int unsigned TW     = 48;
  localparam int unsigned AmpW   = 24;
  localparam int unsigned SumW   = 64;
  localparam int unsigned CfgW   = 32;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned OctDepth = 11;

  localparam logic [31:0] Mul1 = 32'h7feb352d;
  localparam logic [31:0] Mul2 = 32'h846ca68b;
  localparam logic [23:0] AmpMax = 24'hFFFFFF;

  typedef enum logic [CfgIdxW-1:0] {
    REG_SEED       = 3'd0,
    REG_CURVE      = 3'd1,
    REG_OCTAVES    = 3'd2,
    REG_BASE_AMP   = 3'd3,
    REG_FREQ_STEP  = 3'd4,
    REG_AMP_STEP   = 3'd5
  } reg_idx_t;

  typedef enum logic [1:0] {
    EASE_LIN  = 2'd0,
    EASE_CUB  = 2'd1,
    EASE_QUIN = 2'd2,
    EASE_RSVD = 2'd3
  } curve_t;

  typedef struct packed {
    logic [31:0] seed;
    curve_t      curve;
    logic [15:0] freq_step;
    logic [15:0] amp_step;
  } cfg_t;

endpackage

### design/gnf_octave.sv
module gnf_octave (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  gnf_pkg::cfg_t       cfg,
  input  logic                in_valid,
  input  logic [47:0]         in_t,
  input  logic [23:0]         in_amp,
  input  logic [3:0]          in_k,
  input  logic signed [63:0]  in_sum,
  output logic                out_valid,
  output logic [47:0]         out_t,
  output logic [23:0]         out_amp,
  output logic [3:0]          out_k,
  output logic signed [63:0]  out_sum
);
  import gnf_pkg::*;

  localparam int Depth = OctDepth;

  logic [Depth-1:0]   v;
  logic [47:0]        t_d [Depth];
  logic [23:0]        a_d [Depth];
  logic [3:0]         k_d [Depth];
  logic signed [63:0] s_d [Depth];

  logic [31:0] h0a, h1a, h0b, h1b, h0c, h1c, h0d, h1d, m0, m1;
  logic [16:0] f1, f2, f3, f4, f5;
  logic [33:0] sq;
  logic [49:0] cub_p;
  logic [33:0] cub_a;
  logic [33:0] cube_lo;
  logic [32:0] p3;
  logic [51:0] inner;
  logic [19:0] g;
  logic [16:0] ease, ease_b, ease_c;
  logic signed [16:0] s0, s1;
  logic signed [33:0] y0, y1, y0_b, y0_c;
  logic signed [35:0] dy;
  logic signed [53:0] dya;
  logic signed [34:0] r;
  logic signed [59:0] ra;
  logic [39:0] amp_p;
  logic [23:0] amp_sc;
  logic [47:0] t_sc;
  logic [63:0] tp;
  logic [31:0] lat;
  logic        act;

  function automatic logic [31:0] xs(input logic [31:0] x, input int unsigned n);
    xs = x ^ (x >> n);
  endfunction

  assign lat = in_t[47:16] + cfg.seed;
  assign m0  = xs(h0d, 16);
  assign m1  = xs(h1d, 16);
  assign act = (k_d[Depth-2] != 4'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[Depth-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t_d[0] <= in_t; a_d[0] <= in_amp; k_d[0] <= in_k; s_d[0] <= in_sum;
      t_d[1] <= t_sc; a_d[1] <= a_d[0]; k_d[1] <= k_d[0]; s_d[1] <= s_d[0];
      for (int i = 2; i < Depth-1; i++) begin
        t_d[i] <= t_d[i-1]; a_d[i] <= a_d[i-1];
        k_d[i] <= k_d[i-1]; s_d[i] <= s_d[i-1];
      end
      t_d[Depth-1] <= t_d[Depth-2];
      a_d[Depth-1] <= amp_sc;
      k_d[Depth-1] <= act ? k_d[Depth-2] - 4'd1 : 4'd0;
      s_d[Depth-1] <= act ? s_d[Depth-2] + 64'(ra) : s_d[Depth-2];
      h0a <= xs(lat, 16);
      h1a <= xs(lat + 32'd1, 16);
      h0b <= h0a * Mul1;
      h1b <= h1a * Mul1;
      h0c <= xs(h0b, 15);
      h1c <= xs(h1b, 15);
      h0d <= h0c * Mul2;
      h1d <= h1c * Mul2;
      s0 <= $signed({1'b0, m0[31:16]}) - 17'sd32768;
      s1 <= $signed({1'b0, m1[31:16]}) - 17'sd32768;
      f1 <= {1'b0, in_t[15:0]};
      f2 <= f1; f3 <= f2; f4 <= f3; f5 <= f4;
      sq <= f1 * f1;
      cub_p <= 50'(sq) * (50'd196608 - 50'({f2[15:0], 1'b0}));
      cub_a <= 34'((cub_p + 50'h80000000) >> 32);
      cube_lo <= 34'((51'(sq) * 51'(f2)) >> 16);
      inner <= 52'd6 * 52'(sq) + 52'h0A_0000_0000 - 52'd983040 * 52'(f2);
      p3 <= 33'(cube_lo);
      g <= 20'(inner >> 16);
      case (cfg.curve)
        EASE_CUB:  ease <= 17'(cub_a);
        EASE_QUIN: ease <= 17'((53'(p3) * 53'(g) + 53'h80000000) >> 32);
        default:   ease <= f4;
      endcase
      ease_b <= ease;
      ease_c <= ease_b;
      y0 <= s0 * $signed({1'b0, f5});
      y1 <= s1 * ($signed({1'b0, f5}) - 34'sd65536);
      dy <= 36'(y1) - 36'(y0);
      y0_b <= y0;
      dya <= 54'(dy) * $signed({1'b0, ease_c});
      y0_c <= y0_b;
      r <= 35'(y0_c) + 35'((dya + 54'sd32768) >>> 16);
      ra <= 60'(r) * $signed({1'b0, a_d[8]});
    end
  end

  assign tp     = $signed({{16{t_d[0][47]}}, t_d[0]}) * $signed({1'b0, cfg.freq_step});
  assign t_sc   = tp[55:8];
  assign amp_p  = a_d[Depth-2] * cfg.amp_step;
  assign amp_sc = (amp_p[39:12] > 28'(AmpMax)) ? AmpMax : amp_p[35:12];

  assign out_valid = v[Depth-1];
  assign out_t     = t_d[Depth-1];
  assign out_amp   = a_d[Depth-1];
  assign out_k     = k_d[Depth-1];
  assign out_sum   = s_d[Depth-1];

endmodule

### design/gradient_noise_fbm_1d.sv
// Channel  Direction  Handshake                 Payload
// in       input      in_valid / in_stall       coord
// out      output     out_valid / out_stall     noise_sum
// cfg      input      cfg_we                    cfg_index, cfg_data
// One coordinate per cycle while the pipeline is not held; each coordinate passes through all
// MAX_OCTAVES octave units plus one output register, whatever octave_count holds.
// Each octave is its own pipelined unit, all always present.
// Reset clears the valid bits and sets the config registers to their reset values.
// A stall on out while out_valid is high holds the whole pipeline; in_stall follows it.
module gradient_noise_fbm_1d #(
  parameter int MAX_OCTAVES = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic signed [31:0]  coord,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [31:0]  noise_sum
);
  import gnf_pkg::*;

  cfg_t cfg;
  logic [3:0]  octave_count;
  logic [15:0] base_amplitude;
  logic [3:0]  n_oct;

  logic               v  [MAX_OCTAVES+1];
  logic [47:0]        t  [MAX_OCTAVES+1];
  logic [23:0]        a  [MAX_OCTAVES+1];
  logic [3:0]         k  [MAX_OCTAVES+1];
  logic signed [63:0] s  [MAX_OCTAVES+1];
  logic               en;
  logic signed [63:0] rnd;

  assign en = !(out_valid && out_stall);
  assign in_stall = !en;
  assign n_oct = (32'(octave_count) > MAX_OCTAVES) ? 4'(MAX_OCTAVES) : octave_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.seed <= '0; cfg.curve <= EASE_LIN; octave_count <= 4'd1;
      base_amplitude <= 16'd4096; cfg.freq_step <= 16'd512; cfg.amp_step <= 16'd2048;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_SEED:      cfg.seed <= cfg_data;
        REG_CURVE:     cfg.curve <= curve_t'(cfg_data[1:0]);
        REG_OCTAVES:   octave_count <= cfg_data[3:0];
        REG_BASE_AMP:  base_amplitude <= cfg_data[15:0];
        REG_FREQ_STEP: cfg.freq_step <= cfg_data[15:0];
        REG_AMP_STEP:  cfg.amp_step <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  assign v[0] = in_valid;
  assign t[0] = {{16{coord[31]}}, coord};
  assign a[0] = {8'd0, base_amplitude};
  assign k[0] = n_oct;
  assign s[0] = '0;

  for (genvar i = 0; i < MAX_OCTAVES; i++) begin : g_oct
    gnf_octave u_oct (
      .clk, .rst, .en, .cfg,
      .in_valid(v[i]), .in_t(t[i]), .in_amp(a[i]), .in_k(k[i]), .in_sum(s[i]),
      .out_valid(v[i+1]), .out_t(t[i+1]), .out_amp(a[i+1]), .out_k(k[i+1]),
      .out_sum(s[i+1])
    );
  end

  assign rnd = (s[MAX_OCTAVES] + 64'sd67108864) >>> 27;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v[MAX_OCTAVES];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (rnd > 64'sd2147483647) noise_sum <= 32'sh7fffffff;
      else if (rnd < -64'sd2147483648) noise_sum <= 32'sh80000000;
      else noise_sum <= rnd[31:0];
    end
  end

`ifndef SYNTHESIS
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(noise_sum)) else $error("output dropped");
  a_stall: assert property (@(posedge clk) disable iff (rst)
    in_stall == (out_valid && out_stall)) else $error("stall mismatch");
  a_known: assert property (@(posedge clk) disable iff (rst)
    !$isunknown(out_valid) && !$isunknown(in_stall)) else $error("unknown handshake");
`endif

endmodule
